// ===== rtl/core/cle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg
// shared types, character codes and echo helpers of the console line editor
// ----------------------------------------------------------------------------
package cle_pkg;

  // control characters
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;

  // line counts never exceed the 6-bit max_line_length register
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned LEN_W   = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // command queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ECHO_CHAR,
    ECHO_CR,
    ECHO_LF,
    ECHO_BS
  } echo_kind_t;

  typedef enum logic [1:0] {
    LINE_NONE,
    LINE_FORCED,
    LINE_END
  } line_op_t;

  typedef struct packed {
    echo_kind_t       echo;
    logic [7:0]       ch;
    line_op_t         line_op;
    logic [CNT_W-1:0] total;
  } cle_cmd_t;

  typedef struct packed {
    logic in_line;
    logic line_done;
  } back_status_t;

  typedef struct packed {
    logic full;
    logic push;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ECHO,
    BK_LINE
  } back_state_t;

  // number of echo bytes per echo kind
  function automatic logic [1:0] echo_count(input echo_kind_t kind);
    logic [1:0] n;
    unique case (kind)
      ECHO_CHAR: n = 2'd1;
      ECHO_CR:   n = 2'd2;
      ECHO_LF:   n = 2'd2;
      ECHO_BS:   n = 2'd3;
      default:   n = 2'd1;
    endcase
    return n;
  endfunction

  // echo byte at a given step of the sequence
  function automatic logic [7:0] echo_byte(input echo_kind_t kind, input logic [7:0] ch,
                                           input logic [1:0] step);
    logic [7:0] b;
    unique case (kind)
      ECHO_CHAR: b = ch;
      ECHO_CR:   b = (step == 2'd0) ? ch : CH_LF;
      ECHO_LF:   b = (step == 2'd0) ? ch : CH_CR;
      ECHO_BS:   b = (step == 2'd1) ? CH_SP : CH_BS;
      default:   b = ch;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/console_line_editor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a byte's first result passes through the command queue, the back-end idle state
// and the result register; results go out one per cycle while out_stall is low,
// and each command taken from the queue passes through the idle state; a byte that
// completes a line holds off input until the whole line has been read out
// reset: fill index, skip count, queue and result valid flag clear, max_line_length
//   returns to 32; the line store is not cleared
// ----------------------------------------------------------------------------
// console_line_editor
// serial console line editor: echo, backspace, escape skipping and line delivery
// ----------------------------------------------------------------------------
module console_line_editor
  import cle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // configuration
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  // received byte requests
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_rx_byte,
  // echo and line result requests
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_kind,
  output logic [7:0]            out_byte,
  output logic [LEN_W-1:0]      out_line_length,
  output logic                  out_last
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  // max_line_length register: the user writes it only while the editor is idle; not enforced here
  logic [CFG_W-1:0] cfg_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_max_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_max_r <= cfg_wr_data;
    end
  end

  // front to queue
  logic          q_push;
  cle_cmd_t      q_push_cmd;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  cle_cmd_t      q_head;
  queue_status_t q_st;

  // front to line store
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_data;

  // handshake between the two ends about the line being read out
  logic          line_pend;
  back_status_t  bk_st;

  assign q_st = '{full: q_full, push: q_push};

  // front end: classifies each byte, updates fill and skip, stores line bytes
  cle_front #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_max    (cfg_max_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .line_done  (bk_st.line_done),
    .q_push     (q_push),
    .q_cmd      (q_push_cmd),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_data   (mem_data),
    .line_pend  (line_pend)
  );

  // command queue lets echo work pile up while results are stalled
  cle_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back end: echo sequences and line read-out into the result register
  cle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mem_we          (mem_we),
    .mem_addr        (mem_addr),
    .mem_data        (mem_data),
    .head_cmd        (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .status          (bk_st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

  // the store must not be overwritten while a line is read out of it
  a_line_guarded : assert property (@(posedge clk) disable iff (!rst_n)
    bk_st.in_line |-> line_pend)
    else $error("line read-out without pending line");

  // the end of a read-out loads the final line byte of the request
  a_done_last : assert property (@(posedge clk) disable iff (!rst_n)
    bk_st.line_done |=> out_valid && out_last && out_kind)
    else $error("line end not marked on result");

  // no command is pushed into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_st.full |-> !q_st.push)
    else $error("command queue overflow");

endmodule
`default_nettype wire

// ===== rtl/core/cle_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_front
// accepts console bytes, tracks fill and skip state, writes the line store
// and queues echo and line commands for the back end
// ----------------------------------------------------------------------------
module cle_front
  import cle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [CFG_W-1:0]              cfg_max,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_rx_byte,
  input  wire logic                          q_full,
  input  wire logic                          line_done,
  output logic                               q_push,
  output cle_cmd_t                           q_cmd,
  output logic                               mem_we,
  output logic [$clog2(LINE_DEPTH)-1:0]      mem_addr,
  output logic [7:0]                         mem_data,
  output logic                               line_pend
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  logic [AW-1:0] fill_r, fill_nxt;
  logic [1:0]    skip_r, skip_nxt;
  logic          pend_r, pend_nxt;
  logic          accept;
  logic [6:0]    cfg_ext;
  logic [6:0]    lim_ext;
  logic [AW-1:0] lim;
  logic [AW-1:0] fill_inc;

  // effective limit: register clamped to 2..LINE_DEPTH, minus one
  always_comb begin
    cfg_ext = {1'b0, cfg_max};
    priority if (cfg_ext < 7'd2) begin
      lim_ext = 7'd1;
    end else if (cfg_ext > 7'(LINE_DEPTH)) begin
      lim_ext = 7'(LINE_DEPTH - 1);
    end else begin
      lim_ext = cfg_ext - 7'd1;
    end
  end
  assign lim = lim_ext[AW-1:0];

  assign in_stall = q_full | pend_r;
  assign accept   = in_valid & ~in_stall;
  assign fill_inc = fill_r + AW'(1);

  always_comb begin
    fill_nxt = fill_r;
    skip_nxt = skip_r;
    pend_nxt = pend_r & ~line_done;
    q_push   = 1'b0;
    q_cmd    = '{echo: ECHO_CHAR, ch: in_rx_byte, line_op: LINE_NONE, total: '0};
    mem_we   = 1'b0;
    mem_addr = fill_r;
    mem_data = in_rx_byte;
    if (accept) begin
      priority if (skip_r != 2'd0) begin
        skip_nxt = skip_r - 2'd1;
      end else if (in_rx_byte == CH_BS) begin
        if (fill_r != '0) begin
          fill_nxt   = fill_r - AW'(1);
          q_push     = 1'b1;
          q_cmd.echo = ECHO_BS;
        end
      end else if (in_rx_byte == CH_ESC) begin
        skip_nxt = 2'd2;
      end else begin
        mem_we = 1'b1;
        q_push = 1'b1;
        priority if (in_rx_byte == CH_CR) begin
          q_cmd.echo = ECHO_CR;
        end else if (in_rx_byte == CH_LF) begin
          q_cmd.echo = ECHO_LF;
        end else begin
          q_cmd.echo = ECHO_CHAR;
        end
        // a forced line always carries exactly the limit, even when the fill
        // ran past it after the limit was lowered
        priority if (fill_inc >= lim) begin
          q_cmd.line_op = LINE_FORCED;
          q_cmd.total   = CNT_W'(lim);
          fill_nxt      = '0;
          pend_nxt      = 1'b1;
        end else if (in_rx_byte == CH_CR || in_rx_byte == CH_LF) begin
          q_cmd.line_op = LINE_END;
          q_cmd.total   = CNT_W'(fill_inc) + CNT_W'(1);
          fill_nxt      = '0;
          pend_nxt      = 1'b1;
        end else begin
          fill_nxt = fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      skip_r <= 2'd0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      skip_r <= skip_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign line_pend = pend_r;

endmodule
`default_nettype wire

// ===== rtl/core/cle_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_cmd_fifo
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module cle_cmd_fifo
  import cle_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  cle_cmd_t      push_cmd,
  input  wire logic     pop,
  output cle_cmd_t      head_cmd,
  output logic          empty,
  output logic          full
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cle_cmd_t       q_mem [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign head_cmd = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cle_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cle_back
// runs queued commands: plays echo sequences and reads completed lines out
// of the line store into the result register
// ----------------------------------------------------------------------------
module cle_back
  import cle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       mem_we,
  input  wire logic [$clog2(LINE_DEPTH)-1:0] mem_addr,
  input  wire logic [7:0]                 mem_data,
  input  cle_cmd_t                        head_cmd,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  output back_status_t                    status,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_kind,
  output logic [7:0]                      out_byte,
  output logic [LEN_W-1:0]                out_line_length,
  output logic                            out_last
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  logic [7:0]       line_mem [LINE_DEPTH];
  logic [7:0]       rd_data_r;

  back_state_t      state_r, state_nxt;
  cle_cmd_t         cmd_r, cmd_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  logic             out_free;
  logic             emit;
  logic             echo_end;
  logic             line_end;

  logic             valid_r;
  logic             kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             last_r, last_nxt;

  assign out_free = ~valid_r | ~out_stall;
  assign emit     = out_free & ((state_r == BK_ECHO) | (state_r == BK_LINE));
  assign echo_end = (step_r == echo_count(cmd_r.echo) - 2'd1);
  assign line_end = (idx_r == cmd_r.total - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = head_cmd;
          step_nxt  = 2'd0;
          state_nxt = BK_ECHO;
        end
      end
      BK_ECHO: begin
        if (emit) begin
          step_nxt = step_r + 2'd1;
          if (echo_end) begin
            idx_nxt   = '0;
            state_nxt = (cmd_r.line_op == LINE_NONE) ? BK_IDLE : BK_LINE;
          end
        end
      end
      BK_LINE: begin
        if (emit) begin
          idx_nxt = idx_r + CNT_W'(1);
          if (line_end) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    kind_nxt = 1'b0;
    byte_nxt = echo_byte(cmd_r.echo, cmd_r.ch, step_r);
    len_nxt  = '0;
    last_nxt = 1'b0;
    status   = '{in_line: (state_r == BK_LINE), line_done: 1'b0};
    unique case (state_r)
      BK_ECHO: begin
        last_nxt = echo_end & (cmd_r.line_op == LINE_NONE);
      end
      BK_LINE: begin
        kind_nxt = 1'b1;
        byte_nxt = rd_data_r;
        if (cmd_r.line_op == LINE_END) begin
          if (line_end) begin
            byte_nxt = CH_LF;
          end else if (idx_r == cmd_r.total - CNT_W'(2)) begin
            byte_nxt = CH_CR;
          end
        end
        if (line_end) begin
          len_nxt          = cmd_r.total[LEN_W-1:0];
          last_nxt         = 1'b1;
          status.line_done = emit;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      step_r  <= 2'd0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      if (out_free) begin
        valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (emit) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      len_r  <= len_nxt;
      last_r <= last_nxt;
    end
  end

  // line store, read one entry ahead of the read index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_addr] <= mem_data;
    end
    rd_data_r <= line_mem[idx_nxt[AW-1:0]];
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_byte        = byte_r;
  assign out_line_length = len_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

// ===== tb/cle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_checker
// watches the byte, result and register ports of the console line editor,
// predicts every echo and line byte, and compares them in order
// ----------------------------------------------------------------------------
module cle_checker
  import cle_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire logic [7:0]       in_rx_byte,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire logic             out_kind,
  input  wire logic [7:0]       out_byte,
  input  wire logic [LEN_W-1:0] out_line_length,
  input  wire logic             out_last,
  output int                    fail_count,
  output int                    pending,
  output int                    echoes_seen,
  output int                    lines_seen
);

  typedef struct packed {
    logic             kind;
    logic [7:0]       ch;
    logic [LEN_W-1:0] len;
    logic             last;
  } tx_byte_t;

  // shadow of the editor state
  logic [7:0]       line_mem [LINE_DEPTH];
  int unsigned      fill;
  int unsigned      skip;
  logic [CFG_W-1:0] max_len;

  // expected echo and line bytes, oldest first
  tx_byte_t echo_line_q[$];
  // newest prediction is held back so that its last flag can still be set
  tx_byte_t held;
  bit       have_held;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 50) begin
      $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  function automatic int unsigned line_limit();
    int unsigned m;
    m = max_len;
    if (m < 2) m = 2;
    if (m > LINE_DEPTH) m = LINE_DEPTH;
    return m - 1;
  endfunction

  task automatic queue_result(input logic kind, input logic [7:0] ch, input int unsigned len);
    if (have_held) echo_line_q.push_back(held);
    held.kind = kind;
    held.ch   = ch;
    held.len  = len[LEN_W-1:0];
    held.last = 1'b0;
    have_held = 1'b1;
  endtask

  // one received byte through the editor
  task automatic edit_byte(input logic [7:0] ch);
    int unsigned lim;
    int unsigned total;
    int unsigned i;
    lim = line_limit();
    have_held = 1'b0;
    if (skip != 0) begin
      skip--;
    end else if (ch == CH_BS) begin
      if (fill > 0) begin
        fill--;
        queue_result(1'b0, CH_BS, 0);
        queue_result(1'b0, CH_SP, 0);
        queue_result(1'b0, CH_BS, 0);
      end
    end else if (ch == CH_ESC) begin
      skip = 2;
    end else begin
      if (fill < LINE_DEPTH) line_mem[fill] = ch;
      queue_result(1'b0, ch, 0);
      if (ch == CH_CR) queue_result(1'b0, CH_LF, 0);
      if (ch == CH_LF) queue_result(1'b0, CH_CR, 0);
      fill++;
      if (fill >= lim) begin
        // full buffer goes out unchanged
        for (i = 0; i < lim && i < LINE_DEPTH; i++) begin
          queue_result(1'b1, line_mem[i], (i + 1 == lim) ? lim : 0);
        end
        fill = 0;
      end else if (ch == CH_CR || ch == CH_LF) begin
        // line end: the terminator becomes cr lf
        total = fill + 1;
        for (i = 0; i + 1 < fill; i++) begin
          queue_result(1'b1, line_mem[i], 0);
        end
        queue_result(1'b1, CH_CR, 0);
        queue_result(1'b1, CH_LF, total);
        fill = 0;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      echo_line_q.push_back(held);
    end
  endtask

  always @(posedge clk) begin
    tx_byte_t want;
    if (!rst_n) begin
      fill    = 0;
      skip    = 0;
      max_len = CFG_RESET;
      echo_line_q.delete();
      fail_count  = 0;
      echoes_seen = 0;
      lines_seen  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (echo_line_q.size() == 0) begin
          report_mismatch("unexpected result byte", out_byte, 0);
        end else begin
          want = echo_line_q.pop_front();
          if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
          if (out_byte !== want.ch) report_mismatch("byte", out_byte, want.ch);
          if (out_line_length !== want.len) begin
            report_mismatch("line length", out_line_length, want.len);
          end
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
          if (!want.kind) echoes_seen++;
          else if (want.len != 0) lines_seen++;
        end
      end
      if (cfg_wr_en) max_len = cfg_wr_data;
      if (in_valid && !in_stall) edit_byte(in_rx_byte);
    end
    pending = echo_line_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the console line editor with directed and random console bytes
// under several buffer sizes, with random idling on both channels; a checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
  import cle_pkg::*;

  localparam int unsigned LINE_DEPTH  = 32;
  localparam int unsigned IDLE_PCT    = 11;   // percent of cycles a side idles
  localparam int unsigned DRAIN_WAIT  = 40;   // editor may still be busy this long
  localparam int unsigned QUIET_LIMIT = 2000; // cycles with no request moving
  localparam int unsigned PHASE_BYTES = 62;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  // block inputs, known from time zero
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic [7:0]       in_rx_byte  = '0;
  logic             out_stall   = 1'b0;

  // block outputs
  logic             in_stall;
  logic             out_valid;
  logic             out_kind;
  logic [7:0]       out_byte;
  logic [LEN_W-1:0] out_line_length;
  logic             out_last;

  // checker results
  int fail_count;
  int pending;
  int echoes_seen;
  int lines_seen;

  // run bookkeeping
  int bytes_sent     = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;
  bit steady         = 1'b0; // no idling on either side while set

  console_line_editor #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_line_length(out_line_length),
    .out_last       (out_last)
  );

  cle_checker #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_line_length(out_line_length),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .echoes_seen    (echoes_seen),
    .lines_seen     (lines_seen)
  );

  // receiver side: random stall cycles, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog: ends the run when no request moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles, %0d results pending",
                 quiet_cycles, pending);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // one byte request; valid stays high into the next byte unless a gap is taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    // in_stall is read before the edge updates it
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // drop valid, let every expected result drain, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // buffer size register, written only while the editor is idle
  task automatic write_limit(input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  // mostly typed lines with random text, mixed with edits, escapes and noise
  task automatic run_random(input int count);
    int start;
    int len;
    int k;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // a typed line: usually short, sometimes long enough to fill the buffer
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 10);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(9) == 0) send_byte(CH_BS);
          else send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        send_byte(($urandom_range(1) == 0) ? CH_CR : CH_LF);
      end else if (pick < 68) begin
        // backspace burst, may run past the start of the line
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) send_byte(CH_BS);
      end else if (pick < 80) begin
        // escape sequence with arbitrary payload, sometimes another escape
        send_byte(CH_ESC);
        send_byte(($urandom_range(4) == 0) ? CH_ESC : 8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
      end else begin
        // raw noise over the full byte range
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    // opening bytes at the reset buffer size: empty-line backspace, range ends,
    // escapes (one arriving while skipping), both terminators
    logic [7:0]       opening [24];
    logic [CFG_W-1:0] limits  [7];
    int               n;
    opening = '{CH_BS, 8'h00, 8'hFF, 8'h41, CH_BS, CH_ESC, CH_ESC, 8'h31,
                8'h32, CH_CR, CH_LF, CH_CR, 8'h7F, 8'h80, 8'h55, 8'hAA,
                CH_BS, CH_LF, CH_ESC, CH_BS, CH_CR, 8'h01, 8'hFE, CH_LF};
    // reset value, both clamp ends and the raw register extremes, some middles
    limits  = '{6'd32, 6'd2, 6'd63, 6'd0, 6'd7, 6'd17, 6'($urandom_range(63))};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < 24; n++) send_byte(opening[n]);

    for (n = 0; n < 7; n++) begin
      write_limit(limits[n]);
      // one whole phase runs without any idling
      steady = (n == 5);
      run_random(PHASE_BYTES);
    end
    steady = 1'b0;

    wait_idle();

    $display("summary: %0d console bytes sent across %0d buffer size settings",
             bytes_sent, settings_used);
    $display("summary: %0d echo bytes and %0d complete lines compared",
             echoes_seen, lines_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cle_pkg.sv
rtl/core/cle_front.sv
rtl/core/cle_cmd_fifo.sv
rtl/core/cle_back.sv
rtl/core/console_line_editor.sv
tb/cle_checker.sv
tb/tb_top.sv
